// File: design/crcfr_pkg.sv
// shared types, codes and the crc byte step for the framed receiver
package crcfr_pkg;

    // largest payload the receiver ever accepts, independent of max_length
    localparam logic [15:0] MAX_PAYLOAD = 16'd1024;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // receiver phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_CMD     = 3'd1,
        PH_LEN_LO  = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC_LO  = 3'd5,
        PH_CRC_HI  = 3'd6,
        PH_END     = 3'd7
    } t_phase;

    // result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD  = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_TOO_LONG = 3'd2,
        KIND_NO_END   = 3'd3,
        KIND_BAD_CRC  = 3'd4
    } t_kind;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_START_BYTE = 2'd0,
        CFG_END_BYTE   = 2'd1,
        CFG_MAX_LENGTH = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_index;

    // one result word
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [9:0]  byte_index;
        logic [7:0]  frame_command;
        logic [10:0] frame_length;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
    } t_result;

    // crc-16 ccitt, msb first, one byte unrolled
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: design/crc_checked_frame_receiver_core.sv
// framed byte receiver with crc-16 check, payload streaming and frame verdicts
//
// Usage:
// - input channel: one received byte per word on i_rx_byte, handshake
//   i_in_valid / o_in_stall; a word is taken when valid is high and stall low.
// - output channel: one result word per payload byte (kind 0) and one verdict
//   word per frame (good, length too large, missing end byte, crc mismatch);
//   handshake o_out_valid / i_out_stall.
// - bytes while hunting, the start byte, command, length and crc bytes give
//   no result word, but for a too-large length, whose high byte gives one.
// - each result word is registered: it enters the output register, or the skid
//   register while the output is stalled, when the byte that causes it is accepted.
// - throughput: one byte per cycle while o_in_stall is low; the crc step is an
//   unrolled 8-bit update in the single stage between input port and result register.
// - when the receiver stalls, one further result word is held in a skid
//   register; o_in_stall rises only while that skid register is occupied.
// - reset (synchronous, active low): hunting for the start byte, registers at
//   start 0x02, end 0x03, max length 1024, both output registers empty.
// - configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is
//   high; write only while the receiver is idle.
module crc_checked_frame_receiver_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic [9:0]  o_byte_index,
    output logic [7:0]  o_frame_command,
    output logic [10:0] o_frame_length,
    output logic [15:0] o_received_crc,
    output logic [15:0] o_computed_crc
);
    import crcfr_pkg::*;

    // configuration registers
    logic [7:0]  r_start_byte;
    logic [7:0]  r_end_byte;
    logic [10:0] r_max_length;

    // frame state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_length, n_length;
    logic [15:0] r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_carried, n_carried;

    // output and skid registers
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;

    logic        in_accept;
    logic        out_take;
    logic        res_valid;
    t_result     res;
    logic [15:0] crc_step;
    logic [15:0] count_inc;
    logic [15:0] len_full;
    logic        len_too_big;

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    assign crc_step    = crc_byte(r_crc, i_rx_byte);
    assign count_inc   = r_count + 16'd1;
    assign len_full    = {i_rx_byte, r_length[7:0]};
    assign len_too_big = (len_full > {5'd0, r_max_length}) || (len_full > MAX_PAYLOAD);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= 8'h02;
            r_end_byte   <= 8'h03;
            r_max_length <= 11'd1024;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_START_BYTE: r_start_byte <= i_cfg_data[7:0];
                CFG_END_BYTE:   r_end_byte   <= i_cfg_data[7:0];
                CFG_MAX_LENGTH: r_max_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_HUNT:    if (i_rx_byte == r_start_byte) n_phase = PH_CMD;
            PH_CMD:     n_phase = PH_LEN_LO;
            PH_LEN_LO:  n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                if (len_too_big) begin
                    n_phase = PH_HUNT;
                end else if (len_full == 16'd0) begin
                    n_phase = PH_CRC_LO;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: if (count_inc >= r_length) n_phase = PH_CRC_LO;
            PH_CRC_LO:  n_phase = PH_CRC_HI;
            PH_CRC_HI:  n_phase = PH_END;
            PH_END:     n_phase = PH_HUNT;
            default:    n_phase = PH_HUNT;
        endcase
    end

    // datapath and result word
    always_comb begin
        n_command = r_command;
        n_length  = r_length;
        n_count   = r_count;
        n_crc     = r_crc;
        n_carried = r_carried;
        res_valid = 1'b0;
        res       = '0;
        res.frame_command = r_command;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == r_start_byte) n_crc = CRC_INIT;
            end
            PH_CMD: begin
                n_command = i_rx_byte;
                n_crc     = crc_step;
            end
            PH_LEN_LO: begin
                n_length = {8'd0, i_rx_byte};
                n_crc    = crc_step;
            end
            PH_LEN_HI: begin
                n_length = len_full;
                n_crc    = crc_step;
                n_count  = 16'd0;
                if (len_too_big) begin
                    n_length  = 16'd0;
                    res_valid = 1'b1;
                    res.kind  = KIND_TOO_LONG;
                end
            end
            PH_PAYLOAD: begin
                n_crc            = crc_step;
                n_count          = count_inc;
                res_valid        = 1'b1;
                res.kind         = KIND_PAYLOAD;
                res.payload_byte = i_rx_byte;
                res.byte_index   = r_count[9:0];
                res.frame_length = r_length[10:0];
            end
            PH_CRC_LO: begin
                n_carried = {8'd0, i_rx_byte};
            end
            PH_CRC_HI: begin
                n_carried = {i_rx_byte, r_carried[7:0]};
            end
            PH_END: begin
                n_length         = 16'd0;
                n_count          = 16'd0;
                res_valid        = 1'b1;
                res.frame_length = r_length[10:0];
                res.computed_crc = r_crc;
                if (i_rx_byte != r_end_byte) begin
                    res.kind = KIND_NO_END;
                end else begin
                    res.received_crc = r_carried;
                    res.kind = (r_crc != r_carried) ? KIND_BAD_CRC : KIND_GOOD;
                end
            end
            default: begin
                n_length = 16'd0;
                n_count  = 16'd0;
            end
        endcase
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_command <= 8'd0;
            r_length  <= 16'd0;
            r_count   <= 16'd0;
            r_crc     <= CRC_INIT;
            r_carried <= 16'd0;
        end else if (in_accept) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_carried <= n_carried;
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept && res_valid;
            end
        end else if (in_accept && res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_accept && res_valid) begin
                r_out <= res;
            end
        end else if (in_accept && res_valid) begin
            r_skid <= res;
        end
    end

    // output ports
    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_byte_index    = r_out.byte_index;
    assign o_frame_command = r_out.frame_command;
    assign o_frame_length  = r_out.frame_length;
    assign o_received_crc  = r_out.received_crc;
    assign o_computed_crc  = r_out.computed_crc;

endmodule

// File: test/crc_checked_frame_receiver_core_test.sv
// self-checking testbench for the crc-16 framed byte receiver
module crc_checked_frame_receiver_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import crcfr_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int IDLE_WAIT    = 8;

    // ways a generated frame is spoiled
    typedef enum int {
        FR_CLEAN,
        FR_BAD_CRC,
        FR_BAD_END,
        FR_BAD_END_START,
        FR_CUT
    } t_frame_fault;

    // receiver side stall behavior
    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_PERIODIC,
        STALL_HEAVY
    } t_stall_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = CFG_START_BYTE;
    logic [10:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic [9:0]  o_byte_index;
    logic [7:0]  o_frame_command;
    logic [10:0] o_frame_length;
    logic [15:0] o_received_crc;
    logic [15:0] o_computed_crc;

    // receiver shadow: configuration and parse state
    logic [7:0]  cur_start;
    logic [7:0]  cur_end;
    logic [10:0] cur_max;
    t_phase      rx_phase;
    logic [7:0]  rx_cmd;
    logic [15:0] rx_len;
    logic [15:0] rx_count;
    logic [15:0] rx_crc;
    logic [15:0] rx_carried;

    t_result     due_words[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          frame_bytes = 0;

    // sender burst control
    bit          gaps_on     = 1'b1;
    int          burst_left  = 0;

    // receiver stall pattern state
    t_stall_mode stall_mode   = STALL_NONE;
    int          stall_left   = 0;
    int          stall_tick   = 0;
    int          stall_period = 2;
    int          stall_duty   = 1;

    crc_checked_frame_receiver_core uut (.*);

    always #4 i_clk = ~i_clk;

    // crc-16 ccitt, one bit of the byte at a time, msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = r[15] ^ data[k];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // random byte biased toward the framing values
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return cur_start;
        if (r == 1) return cur_end;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic reset_shadow();
        cur_start  = 8'h02;
        cur_end    = 8'h03;
        cur_max    = 11'd1024;
        rx_phase   = PH_HUNT;
        rx_cmd     = '0;
        rx_len     = '0;
        rx_count   = '0;
        rx_crc     = CRC_INIT;
        rx_carried = '0;
        due_words.delete();
    endtask

    // advance the shadow by one accepted byte, queue the word it causes
    task automatic parse_rx_byte(input logic [7:0] b);
        t_result w;
        bit      emit;
        w    = '0;
        emit = 1'b0;
        case (rx_phase)
            PH_HUNT: begin
                if (b == cur_start) begin
                    rx_crc   = CRC_INIT;
                    rx_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                rx_cmd   = b;
                rx_crc   = crc16_step(rx_crc, b);
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                rx_len   = {8'h00, b};
                rx_crc   = crc16_step(rx_crc, b);
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                rx_len[15:8] = b;
                rx_crc       = crc16_step(rx_crc, b);
                rx_count     = '0;
                if (rx_len > cur_max || rx_len > MAX_PAYLOAD) begin
                    w.kind   = KIND_TOO_LONG;
                    emit     = 1'b1;
                    rx_phase = PH_HUNT;
                    rx_len   = '0;
                end else if (rx_len == 0) begin
                    rx_phase = PH_CRC_LO;
                end else begin
                    rx_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                w.kind         = KIND_PAYLOAD;
                w.payload_byte = b;
                w.byte_index   = rx_count[9:0];
                w.frame_length = rx_len[10:0];
                emit           = 1'b1;
                rx_crc         = crc16_step(rx_crc, b);
                rx_count       = rx_count + 16'd1;
                if (rx_count >= rx_len) rx_phase = PH_CRC_LO;
            end
            PH_CRC_LO: begin
                rx_carried = {8'h00, b};
                rx_phase   = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                rx_carried[15:8] = b;
                rx_phase         = PH_END;
            end
            default: begin
                // closing byte: one verdict, back to hunting
                w.frame_length = rx_len[10:0];
                w.computed_crc = rx_crc;
                emit           = 1'b1;
                if (b != cur_end) begin
                    w.kind = KIND_NO_END;
                end else begin
                    w.kind         = (rx_crc != rx_carried) ? KIND_BAD_CRC : KIND_GOOD;
                    w.received_crc = rx_carried;
                end
                rx_phase = PH_HUNT;
                rx_len   = '0;
                rx_count = '0;
            end
        endcase
        if (emit) begin
            w.frame_command = rx_cmd;
            due_words.push_back(w);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // compare one output word with the oldest queued word
    task automatic check_word();
        t_result want;
        if (due_words.size() == 0) begin
            mismatches++;
            $error("result word with none expected, kind 0x%0h", o_kind);
        end else begin
            want = due_words.pop_front();
            compare_field("kind", 16'(want.kind), 16'(o_kind));
            compare_field("payload_byte", 16'(want.payload_byte), 16'(o_payload_byte));
            compare_field("byte_index", 16'(want.byte_index), 16'(o_byte_index));
            compare_field("frame_command", 16'(want.frame_command), 16'(o_frame_command));
            compare_field("frame_length", 16'(want.frame_length), 16'(o_frame_length));
            compare_field("received_crc", want.received_crc, o_received_crc);
            compare_field("computed_crc", want.computed_crc, o_computed_crc);
        end
    endtask

    // monitor: check outputs, track register writes and accepted words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_shadow();
        end else begin
            if (o_out_valid && !i_out_stall) check_word();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_BYTE: cur_start = i_cfg_data[7:0];
                    CFG_END_BYTE:   cur_end   = i_cfg_data[7:0];
                    CFG_MAX_LENGTH: cur_max   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) parse_rx_byte(i_rx_byte);
        end
    end

    // run length guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL crc_checked_frame_receiver_core");
            $finish;
        end
    end

    // receiver stall pattern, chosen anew whenever the current pattern's run ends
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode   = t_stall_mode'($urandom_range(0, 3));
            stall_left   = $urandom_range(8, 80);
            stall_period = $urandom_range(2, 7);
            stall_duty   = $urandom_range(1, stall_period - 1);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_SPARSE:   i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: i_out_stall <= ((stall_tick % stall_period) < stall_duty);
            default:        i_out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // offer one word, wait until it is taken; gaps fall between bursts
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                repeat (gap) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drop valid and wait until every queued word has come out
    task automatic settle_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    // write all registers; upper data bits of the byte registers are junk
    task automatic apply_setting(input logic [7:0] start_val, input logic [7:0] end_val,
                                 input logic [10:0] limit_val, input bit poke_unused);
        logic [2:0] pad_a;
        logic [2:0] pad_b;
        pad_a = 3'($urandom_range(0, 7));
        pad_b = 3'($urandom_range(0, 7));
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_data  <= {pad_a, start_val};
        @(negedge i_clk);
        i_cfg_index <= CFG_END_BYTE;
        i_cfg_data  <= {pad_b, end_val};
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_LENGTH;
        i_cfg_data  <= limit_val;
        if (poke_unused) begin
            @(negedge i_clk);
            i_cfg_index <= CFG_UNUSED;
            i_cfg_data  <= 11'($urandom_range(0, 2047));
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // build one frame for the current registers and send it; fill < 0 is random payload
    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] len,
                              input t_frame_fault fault, input int fill);
        logic [7:0]  seq[$];
        logic [15:0] crc;
        logic [15:0] flip;
        logic [7:0]  b;
        int          cut;
        crc = CRC_INIT;
        seq.push_back(cur_start);
        seq.push_back(cmd);
        seq.push_back(len[7:0]);
        seq.push_back(len[15:8]);
        crc = crc16_step(crc, cmd);
        crc = crc16_step(crc, len[7:0]);
        crc = crc16_step(crc, len[15:8]);
        // an over-long length ends the frame right after its high byte
        if (len <= cur_max && len <= MAX_PAYLOAD) begin
            for (int i = 0; i < len; i++) begin
                b = (fill < 0) ? pick_byte() : fill[7:0];
                crc = crc16_step(crc, b);
                seq.push_back(b);
            end
            if (fault == FR_BAD_CRC) begin
                flip = 16'($urandom_range(1, 65535));
                crc  = crc ^ flip;
            end
            seq.push_back(crc[7:0]);
            seq.push_back(crc[15:8]);
            if (fault == FR_BAD_END_START)
                seq.push_back(cur_start);
            else if (fault == FR_BAD_END)
                seq.push_back(cur_end ^ 8'($urandom_range(1, 255)));
            else
                seq.push_back(cur_end);
        end
        cut = (fault == FR_CUT) ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int i = 0; i < cut; i++) push_byte(seq[i]);
        frame_bytes += cut;
    endtask

    // reset register values, payload byte extremes, crc mismatch
    task automatic test_reset_defaults();
        send_frame(8'h00, 16'd0, FR_CLEAN, 0);
        send_frame(8'hFF, 16'd1, FR_CLEAN, 8'hFF);
        send_frame(8'h5A, 16'd1, FR_BAD_CRC, 8'h00);
        settle_idle();
    endtask

    // hunting noise, wrong closing byte equal to the start byte, length too large
    task automatic test_verdicts();
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(8'h11, 16'd2, FR_BAD_END_START, -1);
        send_frame(8'h22, 16'd0, FR_CLEAN, 0);
        send_frame(8'h33, 16'd1025, FR_CLEAN, 0);
        send_frame(8'h44, 16'hFFFF, FR_CLEAN, 0);
        settle_idle();
    endtask

    // register extremes: zero limit, limit above the payload cap, start equal to end
    task automatic test_config_extremes();
        apply_setting(8'h00, 8'hFF, 11'd0, 1'b1);
        send_frame(8'hA5, 16'd0, FR_CLEAN, 0);
        send_frame(8'hA5, 16'd1, FR_CLEAN, 0);
        settle_idle();
        apply_setting(8'hFF, 8'h00, 11'h7FF, 1'b0);
        send_frame(8'h01, 16'd1025, FR_CLEAN, 0);
        send_frame(8'h80, 16'd3, FR_BAD_END, -1);
        settle_idle();
        apply_setting(8'h7E, 8'h7E, 11'd4, 1'b1);
        send_frame(8'hC0, 16'd4, FR_CLEAN, -1);
        send_frame(8'hC1, 16'd5, FR_CLEAN, -1);
        settle_idle();
    endtask

    // payload exactly at the configured limit, then one byte over it
    task automatic test_limit_frame();
        apply_setting(8'h02, 8'h03, 11'd24, 1'b0);
        send_frame(8'hC3, 16'd24, FR_CLEAN, -1);
        send_frame(8'hC4, 16'd25, FR_CLEAN, -1);
        settle_idle();
    endtask

    // mostly well-formed frames with random content, some spoiled, some noise
    task automatic test_random_traffic();
        logic [7:0]   start_v;
        logic [7:0]   end_v;
        logic [10:0]  limit_v;
        logic [15:0]  len;
        t_frame_fault fault;
        int           limit;
        int           sel;
        int           mark;
        for (int round = 0; round < 5; round++) begin
            start_v = 8'($urandom_range(0, 255));
            end_v   = 8'($urandom_range(0, 255));
            case (round)
                0:       limit_v = 11'($urandom_range(0, 1024));
                1:       limit_v = 11'($urandom_range(0, 16));
                2:       limit_v = 11'h7FF;
                3:       limit_v = 11'($urandom_range(0, 2047));
                default: begin
                    start_v = 8'h02;
                    end_v   = 8'h03;
                    limit_v = 11'd1024;
                end
            endcase
            apply_setting(start_v, end_v, limit_v, 1'($urandom_range(0, 1)));
            mark = frame_bytes;
            while (frame_bytes - mark < 100) begin
                gaps_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 99) < 8) begin
                    repeat ($urandom_range(1, 4)) push_byte(pick_byte());
                end else begin
                    limit = (cur_max < MAX_PAYLOAD) ? cur_max : MAX_PAYLOAD;
                    sel   = $urandom_range(0, 99);
                    if (sel < 65)
                        len = 16'($urandom_range(0, 12));
                    else if (sel < 75)
                        len = 16'($urandom_range(13, 40));
                    else if (sel < 85)
                        len = 16'(limit + 1);
                    else if (sel < 92)
                        len = 16'($urandom_range(limit + 1, 65535));
                    else
                        len = (limit <= 40) ? 16'(limit) : 16'($urandom_range(0, 3));
                    sel = $urandom_range(0, 9);
                    if (sel < 7)       fault = FR_CLEAN;
                    else if (sel == 7) fault = FR_BAD_CRC;
                    else if (sel == 8) fault = FR_BAD_END;
                    else               fault = FR_CUT;
                    send_frame(8'($urandom_range(0, 255)), len, fault, -1);
                end
            end
            gaps_on = 1'b1;
            settle_idle();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_verdicts();
        test_config_extremes();
        test_limit_frame();
        test_random_traffic();
        settle_idle();
        if (mismatches == 0) begin
            $display("PASS crc_checked_frame_receiver_core");
        end else begin
            $display("FAIL crc_checked_frame_receiver_core");
        end
        $finish;
    end

endmodule
